[hw/rtl/qbrf_pkg.sv]
// shared types and constants of the quadratic bisection root finder
// no dependencies
`default_nettype none
package qbrf_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 20;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [2:0] REG_COEF_SQUARE   = 3'd0;
    localparam logic [2:0] REG_COEF_LINEAR   = 3'd1;
    localparam logic [2:0] REG_COEF_CONSTANT = 3'd2;
    localparam logic [2:0] REG_WIDTH_TOL     = 3'd3;
    localparam logic [2:0] REG_ITER_LIMIT    = 3'd4;
    localparam logic [2:0] REG_SCAN_START    = 3'd5;
    localparam logic [2:0] REG_SCAN_END      = 3'd6;
    localparam logic [2:0] REG_SCAN_STEP     = 3'd7;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NO_SIGN = 2'd1;
    localparam logic [1:0] ST_NO_SCAN = 2'd2;

    // polynomial sign codes
    localparam logic [1:0] SG_ZERO = 2'b00;
    localparam logic [1:0] SG_POS  = 2'b01;
    localparam logic [1:0] SG_NEG  = 2'b11;

    function automatic logic opposite(input logic [1:0] a, input logic [1:0] b);
        opposite = (a == SG_POS && b == SG_NEG) || (a == SG_NEG && b == SG_POS);
    endfunction
endpackage
`default_nettype wire

[hw/rtl/qbrf_front.sv]
// front end: accepts request beats and decodes them into queue entries
// depends on qbrf_pkg
`default_nettype none
module qbrf_front #(
    parameter int WORD_BITS = qbrf_pkg::WORD_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire                    i_req_type,
    input  wire  [WORD_BITS-1:0]   i_interval_low,
    input  wire  [WORD_BITS-1:0]   i_interval_high,
    output logic                   o_q_valid,
    input  wire                    i_q_pop,
    output logic                   o_q_scan,
    output logic [WORD_BITS-1:0]   o_q_low,
    output logic [WORD_BITS-1:0]   o_q_high
);
    // two-entry queue
    logic                 r_scan [2];
    logic [WORD_BITS-1:0] r_low  [2];
    logic [WORD_BITS-1:0] r_high [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_scan = r_scan[r_rp];
    assign o_q_low  = r_low[r_rp];
    assign o_q_high = r_high[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
        if (w_push) begin
            r_scan[r_wp] <= i_req_type;
            r_low[r_wp]  <= i_interval_low;
            r_high[r_wp] <= i_interval_high;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/qbrf_eval.sv]
// polynomial sign evaluator, a*x^2 + b*x*2^F + c*2^2F, over several cycles
// depends on qbrf_pkg
`default_nettype none
module qbrf_eval #(
    parameter int WORD_BITS = qbrf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qbrf_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  wire [WORD_BITS-1:0]  i_x,
    input  wire [WORD_BITS-1:0]  i_a,
    input  wire [WORD_BITS-1:0]  i_b,
    input  wire [WORD_BITS-1:0]  i_c,
    output logic                 o_done,
    output logic [1:0]           o_sign
);
    localparam int PW = 3 * WORD_BITS + 2 * FRAC_BITS + 4;
    localparam logic [2:0] E_IDLE = 3'd0;
    localparam logic [2:0] E_AX   = 3'd1;
    localparam logic [2:0] E_MLO  = 3'd2;
    localparam logic [2:0] E_MHI  = 3'd3;
    localparam logic [2:0] E_SUM  = 3'd4;

    logic [2:0] r_st;
    logic signed [WORD_BITS-1:0]   r_x;
    logic signed [2*WORD_BITS:0]   r_t;   // a*x + b*2^F
    logic signed [PW-1:0]          r_p;
    logic signed [PW-1:0]          w_cterm;
    logic signed [2*WORD_BITS:0]   w_plo, w_phi;

    assign w_cterm = PW'(signed'(i_c)) <<< (2 * FRAC_BITS);
    // r_t*x split in two narrow products: low word (unsigned) and high part (signed)
    assign w_plo = signed'({1'b0, r_t[WORD_BITS-1:0]}) * r_x;
    assign w_phi = signed'(r_t[2*WORD_BITS:WORD_BITS]) * r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= E_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_st)
                E_IDLE: if (i_start) r_st <= E_AX;
                E_AX:   r_st <= E_MLO;
                E_MLO:  r_st <= E_MHI;
                E_MHI:  r_st <= E_SUM;
                E_SUM: begin
                    r_st <= E_IDLE;
                    o_done <= 1'b1;
                end
                default: r_st <= E_IDLE;
            endcase
        end
        // horner: (a*x + b*2^F)*x + c*2^2F
        if (r_st == E_IDLE && i_start) r_x <= signed'(i_x);
        if (r_st == E_AX)
            r_t <= (2*WORD_BITS+1)'(signed'(i_a) * r_x)
                 + ((2*WORD_BITS+1)'(signed'(i_b)) <<< FRAC_BITS);
        if (r_st == E_MLO) r_p <= PW'(w_plo);
        if (r_st == E_MHI) r_p <= r_p + (PW'(w_phi) <<< WORD_BITS);
        if (r_st == E_SUM) begin
            if (r_p + w_cterm == '0)     o_sign <= qbrf_pkg::SG_ZERO;
            else if ((r_p + w_cterm) < 0) o_sign <= qbrf_pkg::SG_NEG;
            else                          o_sign <= qbrf_pkg::SG_POS;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/qbrf_back.sv]
// back end: grid scan and bisection sequencer around one shared evaluator
// depends on qbrf_pkg, qbrf_eval
`default_nettype none
module qbrf_back #(
    parameter int WORD_BITS = qbrf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qbrf_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_valid,
    output logic                 o_q_pop,
    input  wire                  i_q_scan,
    input  wire [WORD_BITS-1:0]  i_q_low,
    input  wire [WORD_BITS-1:0]  i_q_high,
    input  wire [WORD_BITS-1:0]  i_coef_square,
    input  wire [WORD_BITS-1:0]  i_coef_linear,
    input  wire [WORD_BITS-1:0]  i_coef_constant,
    input  wire [30:0]           i_width_tolerance,
    input  wire [7:0]            i_iteration_limit,
    input  wire [WORD_BITS-1:0]  i_scan_start,
    input  wire [WORD_BITS-1:0]  i_scan_end,
    input  wire [30:0]           i_scan_step,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [WORD_BITS-1:0] o_root,
    output logic [7:0]           o_iterations_used,
    output logic [1:0]           o_status
);
    localparam logic [WORD_BITS-1:0] SGN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SC0   = 4'd1;  // eval first grid point
    localparam logic [3:0] S_SCCHK = 4'd2;  // loop test
    localparam logic [3:0] S_SCW   = 4'd3;  // wait next grid eval
    localparam logic [3:0] S_EA    = 4'd4;
    localparam logic [3:0] S_EB    = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_EC    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_SW0   = 4'd9;

    logic [3:0] r_st;
    // bounds held in offset binary
    logic [WORD_BITS-1:0] r_lo, r_hi, r_c, r_u;
    logic [1:0] r_sa, r_sb;
    logic [7:0] r_cnt;
    logic r_busy_ev;
    // finished result, held until the output register is free
    logic [WORD_BITS-1:0] r_res_root;
    logic [7:0]           r_res_iters;
    logic [1:0]           r_res_status;

    logic ev_start, ev_done;
    logic [1:0] ev_sign;
    logic [WORD_BITS-1:0] ev_x;
    logic [WORD_BITS:0] w_un, w_width;
    logic [WORD_BITS-1:0] w_mid;
    logic w_load;

    qbrf_eval #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_eval (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(ev_start), .i_x(ev_x ^ SGN),
        .i_a(i_coef_square), .i_b(i_coef_linear), .i_c(i_coef_constant),
        .o_done(ev_done), .o_sign(ev_sign)
    );

    assign w_un = {1'b0, r_u} + (WORD_BITS+1)'(i_scan_step);
    assign w_width = {1'b0, r_hi} - {1'b0, r_lo};
    assign w_mid = (r_lo >> 1) + (r_hi >> 1) + {{(WORD_BITS-1){1'b0}}, r_lo[0] & r_hi[0]};
    assign w_load = (r_st == S_OUT) && (!o_valid || !i_stall);

    always_comb begin
        ev_start = 1'b0;
        ev_x = r_u;
        unique case (r_st)
            S_SC0, S_SCW: begin
                ev_start = !r_busy_ev;
                ev_x = r_u;
            end
            S_EA: begin ev_start = !r_busy_ev; ev_x = r_lo; end
            S_EB: begin ev_start = !r_busy_ev; ev_x = r_hi; end
            S_EC: begin ev_start = !r_busy_ev; ev_x = r_c; end
            default: ;
        endcase
    end

    assign o_q_pop = (r_st == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            o_valid <= 1'b0;
            r_busy_ev <= 1'b0;
        end else begin
            if (w_load) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
            if (ev_start) r_busy_ev <= 1'b1;
            if (ev_done) r_busy_ev <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_q_valid) begin
                    r_cnt <= 8'd0;
                    if (i_q_scan) begin
                        r_u <= i_scan_start ^ SGN;
                        r_st <= (i_scan_step == '0) ? S_SW0 : S_SC0;
                    end else begin
                        r_lo <= i_q_low ^ SGN;
                        r_hi <= i_q_high ^ SGN;
                        r_st <= S_EA;
                    end
                end
                S_SW0: begin
                    r_res_root <= '0; r_res_iters <= '0;
                    r_res_status <= qbrf_pkg::ST_NO_SCAN;
                    r_st <= S_OUT;
                end
                S_SC0: if (ev_done) begin
                    r_sa <= ev_sign;
                    r_st <= S_SCCHK;
                end
                S_SCCHK: begin
                    if (r_u >= (i_scan_end ^ SGN) || w_un[WORD_BITS]) begin
                        r_st <= S_SW0;
                    end else begin
                        r_lo <= r_u;
                        r_u <= w_un[WORD_BITS-1:0];
                        r_st <= S_SCW;
                    end
                end
                S_SCW: if (ev_done) begin
                    if (qbrf_pkg::opposite(r_sa, ev_sign)) begin
                        r_hi <= r_u;
                        r_st <= S_EA;
                    end else begin
                        r_sa <= ev_sign;
                        r_st <= S_SCCHK;
                    end
                end
                S_EA: if (ev_done) begin r_sa <= ev_sign; r_st <= S_EB; end
                S_EB: if (ev_done) begin
                    r_sb <= ev_sign;
                    r_c <= w_mid;
                    if (!qbrf_pkg::opposite(r_sa, ev_sign)) begin
                        r_res_root <= '0; r_res_iters <= '0;
                        r_res_status <= qbrf_pkg::ST_NO_SIGN;
                        r_st <= S_OUT;
                    end else r_st <= S_CHK;
                end
                S_CHK: begin
                    if (w_width[WORD_BITS]
                        || w_width[WORD_BITS-1:0] < WORD_BITS'(i_width_tolerance)
                        || r_cnt >= i_iteration_limit) begin
                        r_res_root <= r_c ^ SGN; r_res_iters <= r_cnt;
                        r_res_status <= qbrf_pkg::ST_FOUND;
                        r_st <= S_OUT;
                    end else begin
                        r_c <= w_mid;
                        r_cnt <= r_cnt + 8'd1;
                        r_st <= S_EC;
                    end
                end
                S_EC: if (ev_done) begin
                    if (ev_sign == qbrf_pkg::SG_ZERO) begin
                        r_res_root <= r_c ^ SGN; r_res_iters <= r_cnt;
                        r_res_status <= qbrf_pkg::ST_FOUND;
                        r_st <= S_OUT;
                    end else begin
                        if (qbrf_pkg::opposite(r_sa, ev_sign)) begin
                            r_hi <= r_c; r_sb <= ev_sign;
                        end else if (qbrf_pkg::opposite(r_sb, ev_sign)) begin
                            r_lo <= r_c; r_sa <= ev_sign;
                        end
                        r_st <= S_CHK;
                    end
                end
                S_OUT: if (w_load) begin
                    o_root <= r_res_root;
                    o_iterations_used <= r_res_iters;
                    o_status <= r_res_status;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hw/rtl/quadratic_bisection_root_finder.sv]
// Bisection root finder for a configured quadratic in signed fixed point (Q11.20 by
// default). The front queue holds two requests; the back end serves one at a time.
// Each polynomial evaluation runs in the shared evaluator; a request costs one
// evaluation per scan grid step plus one per halving step, so time is set by the
// grid steps up to the first sign change and by the halvings. The reset scan
// meets its first sign change after about 990 grid steps. Results sit in an
// output register.
// depends on qbrf_pkg, qbrf_front, qbrf_back
`default_nettype none
module quadratic_bisection_root_finder #(
    parameter int WORD_BITS = qbrf_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qbrf_pkg::FRAC_BITS_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  wire                  i_req_type,
    input  wire [WORD_BITS-1:0]  i_interval_low,
    input  wire [WORD_BITS-1:0]  i_interval_high,
    output logic                 o_valid,
    input  wire                  i_stall,
    output logic [WORD_BITS-1:0] o_root,
    output logic [7:0]           o_iterations_used,
    output logic [1:0]           o_status,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire [qbrf_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire [WORD_BITS-1:0]  i_cfg_data
);
    logic [WORD_BITS-1:0] r_a, r_b, r_c, r_ss, r_se;
    logic [30:0] r_tol, r_step;
    logic [7:0]  r_lim;
    logic q_valid, q_pop, q_scan;
    logic [WORD_BITS-1:0] q_low, q_high;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= WORD_BITS'(64'sd4 <<< FRAC_BITS);
            r_b <= WORD_BITS'(64'sd3 <<< FRAC_BITS);
            r_c <= WORD_BITS'(-(64'sd3 <<< FRAC_BITS));
            r_tol <= 31'd1;
            r_lim <= 8'd100;
            r_ss <= WORD_BITS'(-(64'sd100 <<< FRAC_BITS));
            r_se <= WORD_BITS'(64'sd100 <<< FRAC_BITS);
            r_step <= 31'(((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                qbrf_pkg::REG_COEF_SQUARE:   r_a <= i_cfg_data;
                qbrf_pkg::REG_COEF_LINEAR:   r_b <= i_cfg_data;
                qbrf_pkg::REG_COEF_CONSTANT: r_c <= i_cfg_data;
                qbrf_pkg::REG_WIDTH_TOL:     r_tol <= 31'(i_cfg_data);
                qbrf_pkg::REG_ITER_LIMIT:    r_lim <= i_cfg_data[7:0];
                qbrf_pkg::REG_SCAN_START:    r_ss <= i_cfg_data;
                qbrf_pkg::REG_SCAN_END:      r_se <= i_cfg_data;
                qbrf_pkg::REG_SCAN_STEP:     r_step <= 31'(i_cfg_data);
                default: ;
            endcase
        end
    end

    qbrf_front #(.WORD_BITS(WORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_interval_low(i_interval_low),
        .i_interval_high(i_interval_high), .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_scan(q_scan), .o_q_low(q_low), .o_q_high(q_high)
    );

    qbrf_back #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_scan(q_scan), .i_q_low(q_low), .i_q_high(q_high),
        .i_coef_square(r_a), .i_coef_linear(r_b), .i_coef_constant(r_c),
        .i_width_tolerance(r_tol), .i_iteration_limit(r_lim),
        .i_scan_start(r_ss), .i_scan_end(r_se), .i_scan_step(r_step),
        .o_valid(o_valid), .i_stall(i_stall), .o_root(o_root),
        .o_iterations_used(o_iterations_used), .o_status(o_status)
    );
endmodule
`default_nettype wire
